FILE: hdl/multi_policy_tick_scheduler_macros.svh
// Assertion helpers used by the scheduler sequencer RTL (mpts_seq).
`ifndef MULTI_POLICY_TICK_SCHEDULER_MACROS_SVH
`define MULTI_POLICY_TICK_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MPTS_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define MPTS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define MPTS_CHECK(lbl, cond, msg)
`define MPTS_IMPLY(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/mpts_pkg.sv
package mpts_pkg;

  localparam int MAX_PROCESSES = 32;
  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int SUM_W = (CNT_W + 16 > 21) ? CNT_W + 16 : 21;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_LOAD    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_TICK    = 2'd3;

  localparam logic [2:0] POL_FCFS      = 3'd0;
  localparam logic [2:0] POL_SJF       = 3'd1;
  localparam logic [2:0] POL_SJF_PRE   = 3'd2;
  localparam logic [2:0] POL_PRIO      = 3'd3;
  localparam logic [2:0] POL_PRIO_PRE  = 3'd4;
  localparam logic [2:0] POL_RR        = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 2'd1;

  // process record, arrival in the lowest bits
  typedef struct packed {
    logic [7:0] io_len;
    logic [7:0] io_point;
    logic [3:0] prio;
    logic [7:0] burst;
    logic [7:0] arrival;
  } rec_t;

  // per-slot run state
  typedef struct packed {
    logic [15:0] finish;
    logic        armed;
    logic [7:0]  io_left;
    logic [7:0]  remaining;
  } slot_t;

  typedef struct packed {
    logic        overflow;
    logic [19:0] waiting;
    logic [19:0] turnaround;
    logic [15:0] tick_time;
    logic        all_done;
    logic        idle;
    logic [4:0]  slot;
  } res_t;

  function automatic slot_t slot_init(rec_t r);
    slot_t s;
    s.remaining = r.burst;
    s.io_left   = r.io_len;
    s.armed     = (r.io_point != 8'd0);
    s.finish    = 16'd0;
    return s;
  endfunction

endpackage

FILE: hdl/multi_policy_tick_scheduler.sv
// Multi-policy tick scheduler.
// Requests enter on s_tvalid/s_tready; s_tuser carries the kind (clear table,
// load process, restart run, tick) and s_tdata the process record. Only a tick
// request yields a result on m_tvalid/m_tready; the others yield nothing.
// The cfg channel writes policy (index 0) and the round robin quantum (index 1);
// it is always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. A restart rebuilds each slot's run state
// from its record. A tick is worked by one sequencer over single-port reads of
// the slot memories: admission, minimum search over the ready entries, ready
// list compaction and I/O aging of the waiting entries, plus the totals once
// all processes are done. s_tready is low for the whole of that work.
// The result sits in an output register. While the receiver stalls, the block
// keeps taking requests; a later tick holds its result in the sequencer, with
// s_tready low, until the register is free. Reset empties the table and clears
// all counters, sets policy to FCFS and the quantum to 3.
module multi_policy_tick_scheduler import mpts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,  // arrival, burst_time, prio_level, io_point, io_length
  input  logic [1:0]           s_tuser,  // kind
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,  // running_slot, all_done, tick_time, total_turnaround,
                                         // total_waiting, table_overflow
  output logic                 m_tuser,  // idle
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [2:0] policy;
  logic [7:0] quantum;
  logic       out_free, res_load;
  res_t       res, res_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FCFS;
      quantum <= 8'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POLICY: policy <= cfg_data[2:0];
        REG_QUANTUM: quantum <= cfg_data;
        default: ;
      endcase
    end
  end

  mpts_seq u_seq (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_kind(s_tuser),
    .in_rec(rec_t'(s_tdata[$bits(rec_t)-1:0])),
    .policy(policy),
    .quantum(quantum),
    .out_free(out_free),
    .res_load(res_load),
    .res(res)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res_q <= res;
  end

  assign m_tdata = {1'b0, res_q.overflow, res_q.waiting, res_q.turnaround,
                    res_q.tick_time, res_q.all_done, res_q.slot};
  assign m_tuser = res_q.idle;

endmodule

FILE: hdl/mpts_ram.sv
module mpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/mpts_seq.sv
`include "multi_policy_tick_scheduler_macros.svh"

module mpts_seq import mpts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  rec_t       in_rec,
  input  logic [2:0] policy,
  input  logic [7:0] quantum,
  input  logic       out_free,
  output logic       res_load,
  output res_t       res
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_INIT_CHK = 5'd1;
  localparam logic [4:0] S_INIT_WR  = 5'd2;
  localparam logic [4:0] S_ADM_CHK  = 5'd3;
  localparam logic [4:0] S_ADM_TST  = 5'd4;
  localparam logic [4:0] S_SEL      = 5'd5;
  localparam logic [4:0] S_MIN_RD   = 5'd6;
  localparam logic [4:0] S_MIN_SLOT = 5'd7;
  localparam logic [4:0] S_MIN_KEY  = 5'd8;
  localparam logic [4:0] S_TAKE     = 5'd9;
  localparam logic [4:0] S_TAKE_GOT = 5'd10;
  localparam logic [4:0] S_SH_RD    = 5'd11;
  localparam logic [4:0] S_SH_WR    = 5'd12;
  localparam logic [4:0] S_AGE_CHK  = 5'd13;
  localparam logic [4:0] S_AGE_SLOT = 5'd14;
  localparam logic [4:0] S_AGE_UPD  = 5'd15;
  localparam logic [4:0] S_RUN_RD   = 5'd16;
  localparam logic [4:0] S_RUN_UPD  = 5'd17;
  localparam logic [4:0] S_DONE_CHK = 5'd18;
  localparam logic [4:0] S_SUM_CHK  = 5'd19;
  localparam logic [4:0] S_SUM_ACC  = 5'd20;
  localparam logic [4:0] S_OUT      = 5'd21;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [4:0]       state;
  logic [CNT_W-1:0] loaded_cnt, fin_cnt, rdy_cnt, iow_cnt, k, w;
  logic [IDX_W-1:0] run_idx, best_pos, cur_slot;
  logic             run_v, ovf, ran, by_prio, take_last;
  logic [7:0]       slice, best_key;
  logic [15:0]      sim_time;
  logic [SUM_W-1:0] tat_acc, wt_acc;

  // memory ports
  logic             rec_we, st_we, rdy_we, iow_we;
  logic [IDX_W-1:0] rec_waddr, rec_raddr, st_waddr, st_raddr;
  logic [IDX_W-1:0] rdy_waddr, rdy_raddr, iow_waddr, iow_raddr;
  rec_t             rec_wdata, rec_rdata;
  slot_t            st_wdata, st_rdata;
  logic [IDX_W-1:0] rdy_wdata, rdy_rdata, iow_wdata, iow_rdata;

  mpts_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_PROCESSES)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );
  mpts_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_PROCESSES)) u_st (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  mpts_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCESSES)) u_rdy (
    .clk(clk), .we(rdy_we), .waddr(rdy_waddr), .wdata(rdy_wdata),
    .raddr(rdy_raddr), .rdata(rdy_rdata)
  );
  mpts_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCESSES)) u_iow (
    .clk(clk), .we(iow_we), .waddr(iow_waddr), .wdata(iow_wdata),
    .raddr(iow_raddr), .rdata(iow_rdata)
  );

  logic       is_pre, is_nonpre, is_rr, expire, sel_push, rdy_room, iow_room;
  logic       adm_hit, age_release, key_win, run_finish, run_io, done;
  logic [7:0] cur_key, rem_dec, used_io;
  logic [8:0] used;
  logic [15:0] tat;
  logic [CNT_W-1:0] rdy_after;

  assign in_ready  = (state == S_IDLE);
  assign rdy_room  = (rdy_cnt < CNT_MAX);
  assign iow_room  = (iow_cnt < CNT_MAX);
  assign is_pre    = (policy == POL_SJF_PRE) || (policy == POL_PRIO_PRE);
  assign is_nonpre = (policy == POL_SJF) || (policy == POL_PRIO);
  assign is_rr     = (policy == POL_RR);
  assign expire    = run_v && (slice >= quantum);
  assign sel_push  = (is_pre && run_v) || (is_rr && expire);
  assign rdy_after = rdy_cnt + ((sel_push && rdy_room) ? CNT_ONE : '0);
  assign adm_hit   = ({8'd0, rec_rdata.arrival} == sim_time);
  assign age_release = (st_rdata.io_left <= 8'd1);
  assign cur_key   = by_prio ? {4'd0, rec_rdata.prio} : st_rdata.remaining;
  assign key_win   = (k == '0) || (cur_key < best_key) || (take_last && cur_key == best_key);
  assign rem_dec   = (st_rdata.remaining != 8'd0) ? st_rdata.remaining - 8'd1 : 8'd0;
  assign run_finish = (rem_dec == 8'd0);
  assign run_io    = st_rdata.armed && ((rec_rdata.burst - rem_dec) == rec_rdata.io_point);
  assign done      = (fin_cnt >= loaded_cnt);
  assign tat       = (st_rdata.finish > {8'd0, rec_rdata.arrival}) ?
                     st_rdata.finish - {8'd0, rec_rdata.arrival} : 16'd0;
  assign used_io   = ((rec_rdata.io_point != 8'd0) && !st_rdata.armed) ? rec_rdata.io_len : 8'd0;
  assign used      = {1'b0, rec_rdata.burst} + {1'b0, used_io};

  always_comb begin
    rec_we = 1'b0; rec_waddr = '0; rec_wdata = in_rec; rec_raddr = '0;
    st_we = 1'b0;  st_waddr = '0;  st_wdata = slot_init(in_rec); st_raddr = '0;
    rdy_we = 1'b0; rdy_waddr = rdy_cnt[IDX_W-1:0]; rdy_wdata = '0; rdy_raddr = '0;
    iow_we = 1'b0; iow_waddr = '0; iow_wdata = '0; iow_raddr = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_kind == KIND_LOAD && loaded_cnt < CNT_MAX) begin
          rec_we = 1'b1;
          rec_waddr = loaded_cnt[IDX_W-1:0];
          st_we = 1'b1;
          st_waddr = loaded_cnt[IDX_W-1:0];
        end
      end
      S_INIT_CHK, S_ADM_CHK: rec_raddr = k[IDX_W-1:0];
      S_INIT_WR: begin
        st_we = 1'b1;
        st_waddr = k[IDX_W-1:0];
        st_wdata = slot_init(rec_rdata);
      end
      S_ADM_TST: begin
        rdy_we = adm_hit && rdy_room;
        rdy_wdata = k[IDX_W-1:0];
      end
      S_SEL: begin
        rdy_we = sel_push && rdy_room;
        rdy_wdata = run_idx;
      end
      S_MIN_RD: rdy_raddr = k[IDX_W-1:0];
      S_MIN_SLOT: begin
        rec_raddr = rdy_rdata;
        st_raddr = rdy_rdata;
      end
      S_TAKE: rdy_raddr = best_pos;
      S_SH_RD: rdy_raddr = IDX_W'(k + CNT_ONE);
      S_SH_WR: begin
        rdy_we = 1'b1;
        rdy_waddr = k[IDX_W-1:0];
        rdy_wdata = rdy_rdata;
      end
      S_AGE_CHK: iow_raddr = k[IDX_W-1:0];
      S_AGE_SLOT: st_raddr = iow_rdata;
      S_AGE_UPD: begin
        st_we = 1'b1;
        st_waddr = cur_slot;
        st_wdata = st_rdata;
        if (age_release) begin
          st_wdata.io_left = 8'd0;
          rdy_we = rdy_room;
          rdy_wdata = cur_slot;
        end else begin
          st_wdata.io_left = st_rdata.io_left - 8'd1;
          iow_we = 1'b1;
          iow_waddr = w[IDX_W-1:0];
          iow_wdata = cur_slot;
        end
      end
      S_RUN_RD: begin
        rec_raddr = run_idx;
        st_raddr = run_idx;
      end
      S_RUN_UPD: begin
        st_we = 1'b1;
        st_waddr = run_idx;
        st_wdata = st_rdata;
        st_wdata.remaining = rem_dec;
        if (run_finish) begin
          st_wdata.finish = sim_time;
        end else if (run_io) begin
          st_wdata.armed = 1'b0;
          iow_we = iow_room;
          iow_waddr = iow_cnt[IDX_W-1:0];
          iow_wdata = run_idx;
        end
      end
      S_SUM_CHK: begin
        rec_raddr = k[IDX_W-1:0];
        st_raddr = k[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      loaded_cnt <= '0; fin_cnt <= '0; rdy_cnt <= '0; iow_cnt <= '0;
      k <= '0; w <= '0;
      run_idx <= '0; run_v <= 1'b0; slice <= 8'd0; sim_time <= 16'd0;
      ovf <= 1'b0; ran <= 1'b0;
      best_pos <= '0; best_key <= 8'd0; cur_slot <= '0;
      by_prio <= 1'b0; take_last <= 1'b0;
      tat_acc <= '0; wt_acc <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (in_kind)
              KIND_CLEAR, KIND_RESTART: begin
                if (in_kind == KIND_CLEAR) begin
                  loaded_cnt <= '0;
                  ovf <= 1'b0;
                end
                sim_time <= 16'd0;
                rdy_cnt <= '0; iow_cnt <= '0; fin_cnt <= '0;
                run_idx <= '0; run_v <= 1'b0; slice <= 8'd0;
                k <= '0;
                state <= S_INIT_CHK;
              end
              KIND_LOAD: begin
                if (loaded_cnt < CNT_MAX) begin
                  loaded_cnt <= loaded_cnt + CNT_ONE;
                end else begin
                  ovf <= 1'b1;
                end
              end
              default: begin
                ran <= 1'b0;
                tat_acc <= '0;
                wt_acc <= '0;
                k <= '0;
                state <= (fin_cnt < loaded_cnt) ? S_ADM_CHK : S_DONE_CHK;
              end
            endcase
          end
        end
        S_INIT_CHK: state <= (k < loaded_cnt) ? S_INIT_WR : S_IDLE;
        S_INIT_WR: begin
          k <= k + CNT_ONE;
          state <= S_INIT_CHK;
        end
        S_ADM_CHK: state <= (k < loaded_cnt) ? S_ADM_TST : S_SEL;
        S_ADM_TST: begin
          if (adm_hit && rdy_room) begin
            rdy_cnt <= rdy_cnt + CNT_ONE;
          end
          k <= k + CNT_ONE;
          state <= S_ADM_CHK;
        end
        S_SEL: begin
          rdy_cnt <= rdy_after;
          k <= '0;
          w <= '0;
          best_pos <= '0;
          by_prio <= (policy == POL_PRIO) || (policy == POL_PRIO_PRE);
          take_last <= is_pre;
          state <= S_AGE_CHK;
          if (is_pre) begin
            run_v <= 1'b0;
            if (rdy_after != '0) state <= S_MIN_RD;
          end else if (is_nonpre) begin
            if (!run_v && rdy_cnt != '0) state <= S_MIN_RD;
          end else if (is_rr) begin
            if (expire) begin
              run_v <= 1'b0;
              slice <= 8'd0;
            end
            if ((!run_v || expire) && rdy_after != '0) state <= S_TAKE;
          end else begin
            if (!run_v && rdy_cnt != '0) state <= S_TAKE;
          end
        end
        S_MIN_RD: state <= S_MIN_SLOT;
        S_MIN_SLOT: state <= S_MIN_KEY;
        S_MIN_KEY: begin
          if (key_win) begin
            best_pos <= k[IDX_W-1:0];
            best_key <= cur_key;
          end
          if (k + CNT_ONE < rdy_cnt) begin
            k <= k + CNT_ONE;
            state <= S_MIN_RD;
          end else begin
            state <= S_TAKE;
          end
        end
        S_TAKE: state <= S_TAKE_GOT;
        S_TAKE_GOT: begin
          run_idx <= rdy_rdata;
          run_v <= 1'b1;
          if (is_rr) slice <= 8'd0;
          k <= CNT_W'(best_pos);
          if (CNT_W'(best_pos) + CNT_ONE < rdy_cnt) begin
            state <= S_SH_RD;
          end else begin
            rdy_cnt <= rdy_cnt - CNT_ONE;
            k <= '0;
            w <= '0;
            state <= S_AGE_CHK;
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          // close the gap one entry at a time
          if (k + CNT_W'(2) < rdy_cnt) begin
            k <= k + CNT_ONE;
            state <= S_SH_RD;
          end else begin
            rdy_cnt <= rdy_cnt - CNT_ONE;
            k <= '0;
            w <= '0;
            state <= S_AGE_CHK;
          end
        end
        S_AGE_CHK: begin
          if (k < iow_cnt) begin
            state <= S_AGE_SLOT;
          end else begin
            iow_cnt <= w;
            state <= S_RUN_RD;
          end
        end
        S_AGE_SLOT: begin
          cur_slot <= iow_rdata;
          state <= S_AGE_UPD;
        end
        S_AGE_UPD: begin
          if (age_release) begin
            if (rdy_room) rdy_cnt <= rdy_cnt + CNT_ONE;
          end else begin
            w <= w + CNT_ONE;
          end
          k <= k + CNT_ONE;
          state <= S_AGE_CHK;
        end
        S_RUN_RD: begin
          if (sim_time != 16'hFFFF) sim_time <= sim_time + 16'd1;
          state <= run_v ? S_RUN_UPD : S_DONE_CHK;
        end
        S_RUN_UPD: begin
          ran <= 1'b1;
          cur_slot <= run_idx;
          if (slice != 8'hFF) slice <= slice + 8'd1;
          if (run_finish) begin
            fin_cnt <= fin_cnt + CNT_ONE;
            run_v <= 1'b0;
            slice <= 8'd0;
          end else if (run_io) begin
            if (iow_room) iow_cnt <= iow_cnt + CNT_ONE;
            run_v <= 1'b0;
            slice <= 8'd0;
          end
          state <= S_DONE_CHK;
        end
        S_DONE_CHK: begin
          k <= '0;
          state <= done ? S_SUM_CHK : S_OUT;
        end
        S_SUM_CHK: state <= (k < loaded_cnt) ? S_SUM_ACC : S_OUT;
        S_SUM_ACC: begin
          tat_acc <= tat_acc + SUM_W'(tat);
          if (tat > {7'd0, used}) begin
            wt_acc <= wt_acc + SUM_W'(tat - {7'd0, used});
          end
          k <= k + CNT_ONE;
          state <= S_SUM_CHK;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_load = (state == S_OUT) && out_free;

  always_comb begin
    res.slot       = ran ? 5'(cur_slot) : 5'd0;
    res.idle       = !ran;
    res.all_done   = done;
    res.tick_time  = sim_time;
    res.turnaround = (|tat_acc[SUM_W-1:20]) ? 20'hFFFFF : tat_acc[19:0];
    res.waiting    = (|wt_acc[SUM_W-1:20]) ? 20'hFFFFF : wt_acc[19:0];
    res.overflow   = ovf;
  end

  `MPTS_CHECK(a_rdy_bound, rdy_cnt <= CNT_MAX, "ready list count out of range")
  `MPTS_CHECK(a_iow_bound, iow_cnt <= CNT_MAX, "io wait count out of range")
  `MPTS_CHECK(a_fin_bound, fin_cnt <= loaded_cnt, "finished count passed loaded count")
  `MPTS_IMPLY(a_run_slot, run_v, CNT_W'(run_idx) < loaded_cnt, "running slot not loaded")
  `MPTS_IMPLY(a_res_state, res_load, state == S_OUT, "result loaded outside output step")

endmodule

FILE: tb/sv/sched_checker.sv
module sched_checker import mpts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [39:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [63:0]          m_tdata,
  input  logic                 m_tuser,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]  slot;
    logic        idle;
    logic        all_done;
    logic [15:0] tick_time;
    logic [19:0] turnaround;
    logic [19:0] waiting;
    logic        overflow;
  } tick_report_t;

  tick_report_t tick_reports[$];

  rec_t        recs [MAX_PROCESSES];
  logic [7:0]  rem_ticks [MAX_PROCESSES];
  logic [7:0]  io_ticks [MAX_PROCESSES];
  logic        io_pending [MAX_PROCESSES];
  logic [15:0] done_at [MAX_PROCESSES];
  int unsigned ready_q [MAX_PROCESSES];
  int unsigned io_q [MAX_PROCESSES];
  int unsigned n_ready, n_io, n_loaded, n_finished, cur_slot, slice, now;
  bit          cur_busy, dropped_load;
  logic [2:0]  policy;
  logic [7:0]  quantum;

  function automatic void init_slot(int unsigned s);
    rem_ticks[s]  = recs[s].burst;
    io_ticks[s]   = recs[s].io_len;
    io_pending[s] = (recs[s].io_point != 8'd0);
    done_at[s]    = 16'd0;
  endfunction

  function automatic void rewind();
    now = 0; n_ready = 0; n_io = 0; n_finished = 0;
    cur_slot = 0; cur_busy = 0; slice = 0;
    for (int unsigned i = 0; i < n_loaded; i++) init_slot(i);
  endfunction

  function automatic void enqueue_ready(int unsigned s);
    if (n_ready < MAX_PROCESSES) begin
      ready_q[n_ready] = s;
      n_ready++;
    end
  endfunction

  function automatic int unsigned dequeue_ready(int unsigned pos);
    int unsigned s;
    s = ready_q[pos];
    for (int unsigned k = pos; k + 1 < n_ready; k++) ready_q[k] = ready_q[k+1];
    n_ready--;
    return s;
  endfunction

  function automatic int unsigned min_position(bit by_prio, bit take_last);
    int unsigned best, bkey, key;
    best = 0; bkey = 0;
    for (int unsigned k = 0; k < n_ready; k++) begin
      key = by_prio ? recs[ready_q[k]].prio : rem_ticks[ready_q[k]];
      if (k == 0 || key < bkey || (take_last && key == bkey)) begin
        best = k;
        bkey = key;
      end
    end
    return best;
  endfunction

  function automatic void choose_process();
    if (policy == POL_SJF_PRE || policy == POL_PRIO_PRE) begin
      if (cur_busy) begin
        enqueue_ready(cur_slot);
        cur_busy = 0;
      end
      if (n_ready > 0) begin
        cur_slot = dequeue_ready(min_position(policy == POL_PRIO_PRE, 1));
        cur_busy = 1;
      end
    end else if (policy == POL_SJF || policy == POL_PRIO) begin
      if (!cur_busy && n_ready > 0) begin
        cur_slot = dequeue_ready(min_position(policy == POL_PRIO, 0));
        cur_busy = 1;
      end
    end else if (policy == POL_RR) begin
      if (cur_busy && slice >= quantum) begin
        enqueue_ready(cur_slot);
        cur_busy = 0;
        slice = 0;
      end
      if (!cur_busy && n_ready > 0) begin
        cur_slot = dequeue_ready(0);
        cur_busy = 1;
        slice = 0;
      end
    end else if (!cur_busy && n_ready > 0) begin
      cur_slot = dequeue_ready(0);
      cur_busy = 1;
    end
  endfunction

  function automatic void age_io_list();
    int unsigned w, s;
    w = 0;
    for (int unsigned r = 0; r < n_io; r++) begin
      s = io_q[r];
      if (io_ticks[s] <= 1) begin
        io_ticks[s] = 0;
        enqueue_ready(s);
      end else begin
        io_ticks[s]--;
        io_q[w] = s;
        w++;
      end
    end
    n_io = w;
  endfunction

  function automatic tick_report_t run_tick();
    tick_report_t r;
    int unsigned s, tat, used;
    longint unsigned tat_sum, wait_sum;
    bit ran;
    ran = 0; tat_sum = 0; wait_sum = 0;
    r = '0;
    if (n_finished < n_loaded) begin
      for (int unsigned i = 0; i < n_loaded; i++)
        if (recs[i].arrival == now) enqueue_ready(i);
      choose_process();
      age_io_list();
      if (now < 65535) now++;
      if (cur_busy) begin
        s = cur_slot;
        ran = 1;
        r.slot = s[4:0];
        if (rem_ticks[s] > 0) rem_ticks[s]--;
        if (slice < 255) slice++;
        if (rem_ticks[s] == 0) begin
          done_at[s] = now[15:0];
          n_finished++;
          cur_busy = 0;
          slice = 0;
        end else if (io_pending[s] &&
                     (int'(recs[s].burst) - int'(rem_ticks[s])) == int'(recs[s].io_point)) begin
          if (n_io < MAX_PROCESSES) begin
            io_q[n_io] = s;
            n_io++;
          end
          io_pending[s] = 0;
          cur_busy = 0;
          slice = 0;
        end
      end
    end
    r.all_done = (n_finished >= n_loaded);
    if (r.all_done) begin
      for (int unsigned i = 0; i < n_loaded; i++) begin
        tat = (done_at[i] > recs[i].arrival) ? done_at[i] - recs[i].arrival : 0;
        used = recs[i].burst;
        if (recs[i].io_point != 0 && !io_pending[i]) used += recs[i].io_len;
        tat_sum += tat;
        if (tat > used) wait_sum += tat - used;
      end
      r.turnaround = (tat_sum > 64'hFFFFF) ? 20'hFFFFF : tat_sum[19:0];
      r.waiting    = (wait_sum > 64'hFFFFF) ? 20'hFFFFF : wait_sum[19:0];
    end
    if (!ran) r.slot = '0;
    r.idle      = !ran;
    r.tick_time = now[15:0];
    r.overflow  = dropped_load;
    return r;
  endfunction

  function automatic void apply_request(logic [1:0] kind, rec_t rec);
    case (kind)
      KIND_CLEAR: begin
        n_loaded = 0;
        dropped_load = 0;
        rewind();
      end
      KIND_LOAD: begin
        if (n_loaded >= MAX_PROCESSES) begin
          dropped_load = 1;
        end else begin
          recs[n_loaded] = rec;
          init_slot(n_loaded);
          n_loaded++;
        end
      end
      KIND_RESTART: rewind();
      default: tick_reports.push_back(run_tick());
    endcase
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    n_loaded = 0;
    dropped_load = 0;
    policy = POL_FCFS;
    quantum = 8'd3;
    rewind();
  end

  always @(posedge clk) begin
    tick_report_t exp_r;
    if (!rst) begin
      // compare before predicting so a result never matches its own request
      if (m_tvalid && m_tready) begin
        if (tick_reports.size() == 0) begin
          $error("result with no tick request outstanding");
          errors++;
        end else begin
          exp_r = tick_reports.pop_front();
          check_field("running_slot", exp_r.slot, m_tdata[4:0]);
          check_field("idle", exp_r.idle, m_tuser);
          check_field("all_done", exp_r.all_done, m_tdata[5]);
          check_field("tick_time", exp_r.tick_time, m_tdata[21:6]);
          check_field("total_turnaround", exp_r.turnaround, m_tdata[41:22]);
          check_field("total_waiting", exp_r.waiting, m_tdata[61:42]);
          check_field("table_overflow", exp_r.overflow, m_tdata[62]);
        end
      end
      if (s_tvalid && s_tready) apply_request(s_tuser, rec_t'(s_tdata[35:0]));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POLICY) policy = cfg_data[2:0];
        else if (cfg_index == REG_QUANTUM) quantum = cfg_data;
      end
    end
    pending = tick_reports.size();
  end

endmodule

FILE: tb/sv/tb.sv
module tb import mpts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1700;
  localparam int CALM_AFTER  = 1500;
  localparam longint CYCLE_LIMIT = 4000000;

  logic                 clk, rst;
  logic                 s_tvalid, s_tready;
  logic [39:0]          s_tdata;
  logic [1:0]           s_tuser;
  logic                 m_tvalid, m_tready;
  logic [63:0]          m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  int                   errors, pending;
  int                   sent;
  int                   stall_left;
  logic                 hold_off;
  longint               cycles;

  multi_policy_tick_scheduler u_dut (.*);

  sched_checker u_chk (.*);

  initial begin
    clk = 0;
    rst = 1;
    s_tvalid = 0; s_tdata = '0; s_tuser = KIND_CLEAR;
    m_tready = 0;
    cfg_valid = 0; cfg_index = REG_POLICY; cfg_data = '0;
    hold_off = 0;
    stall_left = 0;
    sent = 0;
    cycles = 0;
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: short random stalls, none near the end
  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 0;
    end else if (sent < CALM_AFTER && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  // long receiver hold-off so the output register fills and the input stalls
  initial begin
    wait (sent >= 600);
    @(posedge clk);
    hold_off <= 1;
    repeat (3000) @(posedge clk);
    hold_off <= 0;
  end

  task automatic send(logic [1:0] kind, rec_t rec);
    if (sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, rec};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_kind(logic [1:0] kind);
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    send(kind, rec_t'(bits[35:0]));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    // a clear or load leaves no result behind; let it finish
    repeat (400) @(posedge clk);
  endtask

  // write both registers back to back, valid held across the pair
  task automatic write_config(logic [2:0] pol, logic [7:0] q);
    cfg_valid <= 1;
    cfg_index <= REG_POLICY;
    cfg_data  <= {5'd0, pol};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_QUANTUM;
    cfg_data  <= q;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic rec_t make_rec(logic [7:0] arr, logic [7:0] burst, logic [3:0] prio,
                                    logic [7:0] iop, logic [7:0] iol);
    rec_t r;
    r.arrival = arr; r.burst = burst; r.prio = prio; r.io_point = iop; r.io_len = iol;
    return r;
  endfunction

  function automatic rec_t random_rec();
    rec_t r;
    logic [7:0] b;
    if ($urandom_range(0, 19) == 0) begin
      return make_rec(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                      4'($urandom_range(0, 15)), 8'($urandom_range(0, 254)),
                      8'($urandom_range(0, 255)));
    end
    b = 8'($urandom_range(1, 7));
    r = make_rec(8'($urandom_range(0, 10)), b, 4'($urandom_range(0, 15)), 8'd0,
                 8'($urandom_range(0, 4)));
    if (b > 1 && $urandom_range(0, 1)) r.io_point = 8'($urandom_range(1, b - 1));
    return r;
  endfunction

  task automatic scenario();
    int n, ticks, span;
    rec_t r;
    logic [7:0] q;
    drain();
    case ($urandom_range(0, 5))
      0: q = 8'd1;
      1: q = 8'd255;
      default: q = 8'($urandom_range(1, 6));
    endcase
    write_config(3'($urandom_range(0, 5)), q);
    send_kind(KIND_CLEAR);
    n = ($urandom_range(0, 12) == 0) ? $urandom_range(31, 34) : $urandom_range(1, 6);
    span = 12;
    for (int i = 0; i < n; i++) begin
      r = random_rec();
      span += r.burst + r.io_len + 2;
      if (r.arrival > 12) span += r.arrival;
      send(KIND_LOAD, r);
    end
    ticks = (span > 300) ? 300 : span;
    for (int t = 0; t < ticks; t++) begin
      case ($urandom_range(0, 59))
        0: send_kind(KIND_RESTART);
        1: send(KIND_LOAD, random_rec());
        default: send_kind(KIND_TICK);
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extreme records, every request kind, zero-length I/O
    write_config(POL_PRIO_PRE, 8'd1);
    send_kind(KIND_CLEAR);
    send(KIND_LOAD, make_rec(8'd0, 8'd1, 4'd0, 8'd0, 8'd0));
    send(KIND_LOAD, make_rec(8'd255, 8'd255, 4'd15, 8'd254, 8'd255));
    send(KIND_LOAD, make_rec(8'd0, 8'd5, 4'd7, 8'd2, 8'd0));
    send(KIND_LOAD, make_rec(8'd1, 8'd3, 4'd7, 8'd1, 8'd2));
    repeat (6) send_kind(KIND_TICK);
    send(KIND_LOAD, make_rec(8'd2, 8'd2, 4'd0, 8'd0, 8'd0));
    repeat (3) send_kind(KIND_TICK);
    send_kind(KIND_RESTART);
    repeat (4) send_kind(KIND_TICK);
    send_kind(KIND_CLEAR);
    send_kind(KIND_TICK);

    while (sent < ITEM_TARGET) scenario();

    s_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/mpts_pkg.sv
hdl/mpts_ram.sv
hdl/mpts_seq.sv
hdl/multi_policy_tick_scheduler.sv
tb/sv/sched_checker.sv
tb/sv/tb.sv
